FILE: hw/rtl/coleman_liau_readability_grade_macros.svh
// Assertion macros used by the checker of this block.
`ifndef COLEMAN_LIAU_READABILITY_GRADE_MACROS_SVH
`define COLEMAN_LIAU_READABILITY_GRADE_MACROS_SVH

// Checked on every edge outside reset.
`define CLG_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Checked on every edge, reset included.
`define CLG_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/clg_pkg.sv
package clg_pkg;

  // Default width of the three text counters.
  localparam int CLG_COUNT_WIDTH = 16;

  // Reported totals are clamped to this width.
  localparam int CLG_OUT_WIDTH = 16;

  // Grade field and its clamp value.
  localparam int CLG_GRADE_WIDTH = 5;
  localparam logic [CLG_GRADE_WIDTH-1:0] CLG_GRADE_MAX = 5'd16;

  // Extra accumulator bits above the count width; covers the largest weight sum.
  localparam int CLG_ACC_EXTRA = 15;

  // Weights of twice the index numerator, with the rounding half folded in:
  // D(k) = 1176*L - 5920*S - 3060*W - 200*W*k.
  localparam int CLG_TERM_WIDTH = 15;
  localparam logic signed [CLG_TERM_WIDTH-1:0] CLG_LETTER_WEIGHT   = 15'sd1176;
  localparam logic signed [CLG_TERM_WIDTH-1:0] CLG_SENTENCE_WEIGHT = 15'sd5920;
  localparam logic signed [CLG_TERM_WIDTH-1:0] CLG_WORD_WEIGHT     = 15'sd3060;
  localparam int CLG_STEP_WIDTH = 8;
  localparam logic [CLG_STEP_WIDTH-1:0] CLG_STEP_WEIGHT = 8'd200;

  // Handshake between the top level and the grade unit.
  typedef struct packed {
    logic idle;
    logic done;
  } clg_status_t;

endpackage

FILE: hw/rtl/clg_grade.sv
// Grade unit: takes the three counts bit-serially, most significant bit first,
// builds the index numerator in one accumulator, then steps the grade up by
// one per cycle while the rounded threshold is still met.
module clg_grade
  import clg_pkg::*;
#(
  parameter int COUNT_WIDTH = CLG_COUNT_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [COUNT_WIDTH-1:0]     letters,
  input  logic [COUNT_WIDTH-1:0]     words,
  input  logic [COUNT_WIDTH-1:0]     sentences,
  input  logic                       take,
  output clg_status_t                status,
  output logic [CLG_GRADE_WIDTH-1:0] grade
);

  localparam int AW    = COUNT_WIDTH + CLG_ACC_EXTRA;
  localparam int CNT_W = (COUNT_WIDTH > 1) ? $clog2(COUNT_WIDTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCUM,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                  state;
  logic [COUNT_WIDTH-1:0]  l_sh;
  logic [COUNT_WIDTH-1:0]  s_sh;
  logic [COUNT_WIDTH-1:0]  w_sh;
  logic signed [AW-1:0]    acc;
  logic signed [AW-1:0]    step;
  logic [CNT_W-1:0]        bit_cnt;

  logic signed [CLG_TERM_WIDTH-1:0] term;
  logic signed [AW-1:0]             acc_next;
  logic signed [AW-1:0]             step_next;
  logic signed [AW-1:0]             cand;

  // Weight sum for the current bit of each count; all narrow.
  always_comb begin
    term = '0;
    if (l_sh[COUNT_WIDTH-1]) term = term + CLG_LETTER_WEIGHT;
    if (s_sh[COUNT_WIDTH-1]) term = term - CLG_SENTENCE_WEIGHT;
    if (w_sh[COUNT_WIDTH-1]) term = term - CLG_WORD_WEIGHT;
  end

  // Horner steps: double and add the new digit's contribution.
  assign acc_next = {acc[AW-2:0], 1'b0} +
                    {{(AW-CLG_TERM_WIDTH){term[CLG_TERM_WIDTH-1]}}, term};
  assign step_next = {step[AW-2:0], 1'b0} +
                     (w_sh[COUNT_WIDTH-1] ?
                      {{(AW-CLG_STEP_WIDTH){1'b0}}, CLG_STEP_WEIGHT} : '0);

  // Threshold for the next grade; negative means the grade is final.
  assign cand = acc - step;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            l_sh    <= letters;
            s_sh    <= sentences;
            w_sh    <= words;
            acc     <= '0;
            step    <= '0;
            bit_cnt <= CNT_W'(COUNT_WIDTH - 1);
            state   <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          acc  <= acc_next;
          step <= step_next;
          l_sh <= {l_sh[COUNT_WIDTH-2:0], 1'b0};
          s_sh <= {s_sh[COUNT_WIDTH-2:0], 1'b0};
          w_sh <= {w_sh[COUNT_WIDTH-2:0], 1'b0};
          if (bit_cnt == '0) begin
            grade <= '0;
            state <= S_SCAN;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_SCAN: begin
          if (grade == CLG_GRADE_MAX || cand[AW-1]) begin
            state <= S_DONE;
          end else begin
            acc   <= cand;
            grade <= grade + 1'b1;
          end
        end
        S_DONE: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.idle = (state == S_IDLE);
  assign status.done = (state == S_DONE);

endmodule

FILE: hw/rtl/coleman_liau_readability_grade.sv
// Counting takes one byte per cycle; s_tready stays high while no grade is in work.
// The item marked last starts the grade unit: it shifts in the counts bit by bit, steps the
// grade up until the threshold fails or the clamp is reached, then hands the result to the
// output register once that is free; no byte is taken meanwhile.
// A finished result waits in the output register while counting goes on.
// Synchronous active-high reset clears all counts, the flag and the output valid, and idles the grade unit.
module coleman_liau_readability_grade
  import clg_pkg::*;
#(
  parameter int COUNT_WIDTH = CLG_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_byte[7:0]
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // grade[4:0], letter_total[20:5], word_total[36:21],
                                 // sentence_total[52:37], count_saturated[53], zero[55:54]
);

  localparam int EW = (COUNT_WIDTH > CLG_OUT_WIDTH) ? COUNT_WIDTH : CLG_OUT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
  localparam logic [EW-1:0] OMAX_EXT = EW'({CLG_OUT_WIDTH{1'b1}});

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUERY   = 8'h3F;

  logic [COUNT_WIDTH-1:0] letters;
  logic [COUNT_WIDTH-1:0] spaces;
  logic [COUNT_WIDTH-1:0] sentences;
  logic                   ovf;

  logic [COUNT_WIDTH-1:0] letters_next;
  logic [COUNT_WIDTH-1:0] spaces_next;
  logic [COUNT_WIDTH-1:0] sentences_next;
  logic                   ovf_next;
  logic [COUNT_WIDTH-1:0] words_next;

  logic [EW-1:0] l_ext;
  logic [EW-1:0] w_ext;
  logic [EW-1:0] s_ext;

  logic [CLG_OUT_WIDTH-1:0] letter_rep;
  logic [CLG_OUT_WIDTH-1:0] word_rep;
  logic [CLG_OUT_WIDTH-1:0] sentence_rep;
  logic                     sat_rep;

  logic [CLG_OUT_WIDTH-1:0] letter_hold;
  logic [CLG_OUT_WIDTH-1:0] word_hold;
  logic [CLG_OUT_WIDTH-1:0] sentence_hold;
  logic                     sat_hold;

  logic                       in_fire;
  logic                       is_letter;
  logic                       is_space;
  logic                       is_stop;
  logic                       start;
  logic                       take;
  clg_status_t                status;
  logic [CLG_GRADE_WIDTH-1:0] grade;

  assign s_tready = status.idle;
  assign in_fire  = s_tvalid & s_tready;
  assign start    = in_fire & s_tlast;
  assign take     = status.done & (~m_tvalid | m_tready);

  // Byte classes.
  assign is_letter = (s_tdata >= CH_LOWER_A && s_tdata <= CH_LOWER_Z) ||
                     (s_tdata >= CH_UPPER_A && s_tdata <= CH_UPPER_Z);
  assign is_space  = (s_tdata == CH_SPACE);
  assign is_stop   = (s_tdata == CH_PERIOD) || (s_tdata == CH_BANG) ||
                     (s_tdata == CH_QUERY);

  // Saturating count updates for the accepted item.
  always_comb begin
    letters_next   = letters;
    spaces_next    = spaces;
    sentences_next = sentences;
    ovf_next       = ovf;
    if (is_letter) begin
      if (letters == CMAX) ovf_next = 1'b1;
      else letters_next = letters + 1'b1;
    end else if (is_space) begin
      if (spaces == CMAX) ovf_next = 1'b1;
      else spaces_next = spaces + 1'b1;
    end else if (is_stop) begin
      if (sentences == CMAX) ovf_next = 1'b1;
      else sentences_next = sentences + 1'b1;
    end
  end

  // Word total is spaces plus one, held at the maximum.
  assign words_next = (spaces_next == CMAX) ? CMAX : spaces_next + 1'b1;

  // Totals clamped to the output width.
  assign l_ext = EW'(letters_next);
  assign w_ext = EW'(words_next);
  assign s_ext = EW'(sentences_next);

  always_comb begin
    letter_rep   = (l_ext > OMAX_EXT) ? {CLG_OUT_WIDTH{1'b1}} : l_ext[CLG_OUT_WIDTH-1:0];
    word_rep     = (w_ext > OMAX_EXT) ? {CLG_OUT_WIDTH{1'b1}} : w_ext[CLG_OUT_WIDTH-1:0];
    sentence_rep = (s_ext > OMAX_EXT) ? {CLG_OUT_WIDTH{1'b1}} : s_ext[CLG_OUT_WIDTH-1:0];
    sat_rep      = ovf_next || (spaces_next == CMAX) || (l_ext > OMAX_EXT) ||
                   (w_ext > OMAX_EXT) || (s_ext > OMAX_EXT);
  end

  // Counters: updated per item, cleared after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      letters   <= '0;
      spaces    <= '0;
      sentences <= '0;
      ovf       <= 1'b0;
    end else if (in_fire) begin
      if (s_tlast) begin
        letters   <= '0;
        spaces    <= '0;
        sentences <= '0;
        ovf       <= 1'b0;
      end else begin
        letters   <= letters_next;
        spaces    <= spaces_next;
        sentences <= sentences_next;
        ovf       <= ovf_next;
      end
    end
  end

  // Totals wait here while the grade is worked out.
  always_ff @(posedge clk) begin
    if (start) begin
      letter_hold   <= letter_rep;
      word_hold     <= word_rep;
      sentence_hold <= sentence_rep;
      sat_hold      <= sat_rep;
    end
  end

  clg_grade #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_grade (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .letters   (letters_next),
    .words     (words_next),
    .sentences (sentences_next),
    .take      (take),
    .status    (status),
    .grade     (grade)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {2'b00, sat_hold, sentence_hold, word_hold, letter_hold, grade};
    end
  end

endmodule

FILE: hw/rtl/clg_checker.sv
// Port-level checks for the readability grade block.
`include "coleman_liau_readability_grade_macros.svh"

module clg_checker
  import clg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // A stalled result item keeps its value.
  `CLG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // The grade never exceeds its clamp.
  `CLG_ASSERT(a_grade_range, m_tvalid |-> m_tdata[4:0] <= CLG_GRADE_MAX)

  // Word total is at least one.
  `CLG_ASSERT(a_words_nonzero, m_tvalid |-> m_tdata[36:21] != 16'd0)

  // The last item of a text closes the input while the grade is in work.
  `CLG_ASSERT(a_busy_after_last, s_tvalid && s_tready && s_tlast |=> !s_tready)

  // Reset leaves no result pending.
  `CLG_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid)

endmodule

bind coleman_liau_readability_grade clg_checker u_clg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: test/coleman_liau_readability_grade_tb.sv
module coleman_liau_readability_grade_tb;
  import clg_pkg::*;

  // Character codes the block reacts to, plus bytes it ignores.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_HIGH    = 8'h80;
  localparam logic [7:0] CH_TOP     = 8'hFF;

  // Coleman-Liau letter and sentence weights scaled by 10000, the constant scaled by 100, and the divisor scale.
  localparam longint LETTER_COEF   = 588;
  localparam longint SENTENCE_COEF = 2960;
  localparam longint WORD_COEF     = 1580;
  localparam longint INDEX_SCALE   = 100;

  localparam longint unsigned COUNT_MAX = (64'd1 << CLG_COUNT_WIDTH) - 64'd1;
  localparam longint unsigned OUT_MAX   = (64'd1 << CLG_OUT_WIDTH) - 64'd1;

  localparam int MAX_WAIT      = 18;
  localparam int RANDOM_ITEMS  = 850;
  localparam int DRAIN_CYCLES  = CLG_COUNT_WIDTH + 24;
  localparam int RUN_LIMIT     = 1000000;

  // One grade item as it leaves on m_tdata, highest field first.
  typedef struct packed {
    logic [1:0]               pad;
    logic                     count_saturated;
    logic [CLG_OUT_WIDTH-1:0] sentence_total;
    logic [CLG_OUT_WIDTH-1:0] word_total;
    logic [CLG_OUT_WIDTH-1:0] letter_total;
    logic [CLG_GRADE_WIDTH-1:0] grade;
  } grade_result_t;

  // Tracks the text counts and the grades still owed by the block.
  class grade_scoreboard;
    longint unsigned letters;
    longint unsigned spaces;
    longint unsigned sentences;
    bit              overflow;
    grade_result_t   owed_grades[$];
    int              errors;

    function longint unsigned bump(longint unsigned n);
      if (n >= COUNT_MAX) begin
        overflow = 1'b1;
        return COUNT_MAX;
      end
      return n + 1;
    endfunction

    function logic [CLG_OUT_WIDTH-1:0] clip(longint unsigned v, inout bit sat);
      if (v > OUT_MAX) begin
        sat = 1'b1;
        return OUT_MAX[CLG_OUT_WIDTH-1:0];
      end
      return v[CLG_OUT_WIDTH-1:0];
    endfunction

    // Index rounded half away from zero; negative numerators grade as zero.
    function logic [CLG_GRADE_WIDTH-1:0] grade_for(longint l, longint w, longint s);
      longint num;
      longint idx;
      num = LETTER_COEF * l - SENTENCE_COEF * s - WORD_COEF * w;
      if (num < 0) return '0;
      idx = (2 * num + INDEX_SCALE * w) / (2 * INDEX_SCALE * w);
      if (idx > CLG_GRADE_MAX) return CLG_GRADE_MAX;
      return idx[CLG_GRADE_WIDTH-1:0];
    endfunction

    function void note_char(logic [7:0] c, logic last);
      grade_result_t   owed;
      longint unsigned words;
      bit              sat;
      if ((c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z))
        letters = bump(letters);
      else if (c == CH_SPACE)
        spaces = bump(spaces);
      else if (c == CH_PERIOD || c == CH_BANG || c == CH_QUERY)
        sentences = bump(sentences);
      if (!last) return;
      // A space count already at its maximum pins the word count there.
      sat = overflow;
      if (spaces >= COUNT_MAX) begin
        words = COUNT_MAX;
        sat = 1'b1;
      end else begin
        words = spaces + 1;
      end
      owed = '0;
      owed.grade = grade_for(letters, words, sentences);
      owed.letter_total = clip(letters, sat);
      owed.word_total = clip(words, sat);
      owed.sentence_total = clip(sentences, sat);
      owed.count_saturated = sat;
      owed_grades.push_back(owed);
      letters = 0;
      spaces = 0;
      sentences = 0;
      overflow = 1'b0;
    endfunction

    function void check_result(grade_result_t got);
      grade_result_t want;
      if (owed_grades.size() == 0) begin
        $error("unexpected result: data %h", got);
        errors++;
        return;
      end
      want = owed_grades.pop_front();
      if (got.grade !== want.grade) begin
        $error("grade: expected %0d, got %0d", want.grade, got.grade);
        errors++;
      end
      if (got.letter_total !== want.letter_total) begin
        $error("letter_total: expected %0d, got %0d", want.letter_total, got.letter_total);
        errors++;
      end
      if (got.word_total !== want.word_total) begin
        $error("word_total: expected %0d, got %0d", want.word_total, got.word_total);
        errors++;
      end
      if (got.sentence_total !== want.sentence_total) begin
        $error("sentence_total: expected %0d, got %0d", want.sentence_total,
               got.sentence_total);
        errors++;
      end
      if (got.count_saturated !== want.count_saturated) begin
        $error("count_saturated: expected %0d, got %0d", want.count_saturated,
               got.count_saturated);
        errors++;
      end
    endfunction

    function int owed_count();
      return owed_grades.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // char_byte[7:0]
  logic        s_tlast = 1'b0; // last_char
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // grade[4:0], letter_total[20:5], word_total[36:21],
                               // sentence_total[52:37], count_saturated[53], zero[55:54]

  grade_scoreboard sb = new();
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;
  bit paused = 1'b0;
  int sent_items = 0;

  coleman_liau_readability_grade dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both sides; a result is checked before the same edge's input is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(grade_result_t'(m_tdata));
      if (s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
    end
  end

  // Overall run limit.
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("coleman_liau_readability_grade regression: fail");
    $finish;
  end

  // Result sink: stalls a random number of cycles before taking each item.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) sink_quiet = !sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Offer one character after a random wait and hold it until taken.
  task automatic push_char(logic [7:0] c, logic last);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic release_source();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Hold off the source until every owed grade has come back.
  task automatic wait_drained();
    release_source();
    while (sb.owed_count() > 0) @(posedge clk);
  endtask

  task automatic send_string(string txt);
    for (int i = 0; i < txt.len(); i++) push_char(txt[i], i == txt.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_terminator();
    case ($urandom_range(0, 2))
      0: return CH_PERIOD;
      1: return CH_BANG;
      default: return CH_QUERY;
    endcase
  endfunction

  // Mostly word-shaped texts with random word lengths; some are pure noise.
  task automatic send_random_text();
    int n_words;
    int max_len;
    int len;
    logic [7:0] closing;
    src_quiet = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 20)) push_char(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      n_words = $urandom_range(0, 10);
      max_len = $urandom_range(1, 14);
      for (int w = 0; w < n_words; w++) begin
        len = $urandom_range(1, max_len);
        for (int k = 0; k < len; k++)
          push_char(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                 : rand_letter(), 1'b0);
        if ($urandom_range(0, 3) == 0) push_char(rand_terminator(), 1'b0);
        if (w < n_words - 1 || $urandom_range(0, 1)) push_char(CH_SPACE, 1'b0);
      end
    end
    case ($urandom_range(0, 3))
      0: closing = 8'($urandom_range(0, 255));
      1: closing = rand_letter();
      2: closing = rand_terminator();
      default: closing = CH_SPACE;
    endcase
    push_char(closing, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty text, then every class boundary and the byte extremes.
    push_char(CH_NUL, 1'b1);
    push_char(CH_UPPER_A, 1'b0);
    push_char(CH_UPPER_Z, 1'b0);
    push_char(CH_LOWER_A, 1'b0);
    push_char(CH_LOWER_Z, 1'b0);
    push_char(CH_UPPER_A - 8'd1, 1'b0);
    push_char(CH_UPPER_Z + 8'd1, 1'b0);
    push_char(CH_LOWER_A - 8'd1, 1'b0);
    push_char(CH_LOWER_Z + 8'd1, 1'b0);
    push_char(CH_SPACE, 1'b0);
    push_char(CH_PERIOD, 1'b0);
    push_char(CH_BANG, 1'b0);
    push_char(CH_QUERY, 1'b0);
    push_char(CH_HIGH, 1'b0);
    push_char(CH_TOP, 1'b1);
    // One long word grades past the top and clamps.
    send_string("Zzzzzzzz");

    // Random texts, with one pause for the owed grades along the way.
    while (sent_items < RANDOM_ITEMS) begin
      send_random_text();
      if (!paused && sent_items >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed_count() == 0)
      $display("coleman_liau_readability_grade regression: pass");
    else
      $display("coleman_liau_readability_grade regression: fail");
    $finish;
  end

endmodule
